FILE: rtl/ascii_uint32_parser_defines.svh
// ----------------------------------------------------------------------------
// ascii_uint32_parser_defines.svh
// Assertion macros shared by the parser's checker.
// ----------------------------------------------------------------------------
`ifndef ASCII_UINT32_PARSER_DEFINES_SVH
`define ASCII_UINT32_PARSER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define AUP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("aup assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define AUP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("aup assertion failed");

`endif

FILE: rtl/aup_pkg.sv
// ----------------------------------------------------------------------------
// aup_pkg
// Types and character constants of the ASCII to uint32 parser.
// ----------------------------------------------------------------------------
package aup_pkg;

  // Item kinds on the input channel
  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // ASCII codes
  localparam logic [7:0] CHAR_0  = 8'h30;
  localparam logic [7:0] CHAR_9  = 8'h39;
  localparam logic [7:0] CHAR_LX = 8'h78;
  localparam logic [7:0] CHAR_UX = 8'h58;
  localparam logic [7:0] CHAR_LA = 8'h61;
  localparam logic [7:0] CHAR_LF = 8'h66;
  localparam logic [7:0] CHAR_UA = 8'h41;
  localparam logic [7:0] CHAR_UF = 8'h46;

  localparam logic [3:0] HEX_LETTER_BASE = 4'd10;

  typedef struct packed {
    logic       kind;
    logic [7:0] character;
  } aup_item_t;

  typedef struct packed {
    logic        valid;
    logic [3:0]  value;
  } aup_digit_t;

  typedef struct packed {
    logic [31:0] value;
    logic        ok;
  } aup_result_t;

endpackage

FILE: rtl/aup_if.sv
// ----------------------------------------------------------------------------
// aup_if
// Valid/ready channels of the parser: character items in, results out.
// ----------------------------------------------------------------------------
interface aup_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] character;

  modport source (output valid, output kind, output character, input ready);
  modport sink   (input valid, input kind, input character, output ready);
endinterface

interface aup_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;
  logic        ok;

  modport source (output valid, output value, output ok, input ready);
  modport sink   (input valid, input value, input ok, output ready);
endinterface

FILE: rtl/aup_digit.sv
// ----------------------------------------------------------------------------
// aup_digit
// Map one ASCII code to its digit value in base ten or sixteen.
// ----------------------------------------------------------------------------
module aup_digit
  import aup_pkg::*;
(
  input  logic [7:0] character,
  input  logic       hex,
  output aup_digit_t digit
);

  logic is_dec;
  logic is_lower;
  logic is_upper;

  assign is_dec   = (character >= CHAR_0)  && (character <= CHAR_9);
  assign is_lower = (character >= CHAR_LA) && (character <= CHAR_LF);
  assign is_upper = (character >= CHAR_UA) && (character <= CHAR_UF);

  always_comb begin
    digit.valid = 1'b0;
    digit.value = '0;
    if (is_dec) begin
      digit.valid = 1'b1;
      digit.value = 4'(character - CHAR_0);
    end else if (hex && is_lower) begin
      digit.valid = 1'b1;
      digit.value = 4'(character - CHAR_LA) + HEX_LETTER_BASE;
    end else if (hex && is_upper) begin
      digit.valid = 1'b1;
      digit.value = 4'(character - CHAR_UA) + HEX_LETTER_BASE;
    end
  end

endmodule

FILE: rtl/aup_core.sv
// ----------------------------------------------------------------------------
// aup_core
// Per-string state: phase, base, accumulator and sticky fault flags.
// ----------------------------------------------------------------------------
module aup_core
  import aup_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  aup_item_t   item,
  input  logic        decimal_only,
  output aup_result_t result
);

  typedef enum logic [1:0] {
    PH_START,
    PH_ZERO,
    PH_PREFIX,
    PH_BODY
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic        hex_r, hex_nxt;
  logic        ovf_r, ovf_nxt;
  logic        bad_r, bad_nxt;

  aup_digit_t  digit;
  logic [35:0] scaled;
  logic [35:0] sum;
  logic        is_x;

  aup_digit u_digit (
    .character (item.character),
    .hex       (hex_r),
    .digit     (digit)
  );

  // acc * 16 or acc * 10 as shifts, then add the digit
  assign scaled = hex_r ? {acc_r, 4'b0000}
                        : ({1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0});
  assign sum    = scaled + {32'd0, digit.value};
  assign is_x   = (item.character == CHAR_LX) || (item.character == CHAR_UX);

  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    hex_nxt   = hex_r;
    ovf_nxt   = ovf_r;
    bad_nxt   = bad_r;
    if (item.kind == KIND_END) begin
      phase_nxt = PH_START;
      acc_nxt   = '0;
      hex_nxt   = 1'b0;
      ovf_nxt   = 1'b0;
      bad_nxt   = 1'b0;
    end else if (phase_r == PH_START && item.character == CHAR_0 && !decimal_only) begin
      phase_nxt = PH_ZERO;
    end else if (phase_r == PH_ZERO && is_x && !decimal_only) begin
      phase_nxt = PH_PREFIX;
      hex_nxt   = 1'b1;
    end else begin
      phase_nxt = PH_BODY;
      if (!digit.valid) begin
        bad_nxt = 1'b1;
      end else if (sum[35:32] != 4'd0) begin
        ovf_nxt = 1'b1;
      end else begin
        acc_nxt = sum[31:0];
      end
    end
  end

  always_comb begin
    result.ok    = (phase_r == PH_ZERO || phase_r == PH_BODY) && !ovf_r && !bad_r;
    result.value = result.ok ? acc_r : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      acc_r   <= '0;
      hex_r   <= 1'b0;
      ovf_r   <= 1'b0;
      bad_r   <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      hex_r   <= hex_nxt;
      ovf_r   <= ovf_nxt;
      bad_r   <= bad_nxt;
    end
  end

endmodule

FILE: rtl/ascii_uint32_parser.sv
// ----------------------------------------------------------------------------
// ascii_uint32_parser
// Streaming parser of decimal or 0x-prefixed hex ASCII strings to uint32.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one transaction per character (kind = 0) or an
//   end-of-string marker (kind = 1). out_ch carries one transaction per
//   end-of-string: the parsed value and an ok flag (value is 0 when not ok).
//   cfg_we/cfg_wdata write decimal_only; write it only while idle.
// Timing:
//   An input register feeds the digit step, which writes the result
//   register. An accepted end-of-string marker passes both registers before
//   its result shows on out_ch. One item is taken per cycle unless a marker
//   waits for the result register; the accumulator multiply-add is combinational.
// Reset (rst_n low at a clock edge, synchronous):
//   Clears the string state, decimal_only and both valid flags.
// Backpressure:
//   Characters keep flowing while a result waits on out_ch. An
//   end-of-string marker holds in the input register until the result
//   register frees, and in_ch.ready stays low while it waits.
// ----------------------------------------------------------------------------
module ascii_uint32_parser
  import aup_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  aup_in_if.sink       in_ch,
  aup_out_if.source    out_ch,
  input  logic         cfg_we,
  input  logic         cfg_wdata
);

  logic        decimal_only_r;

  // input register
  logic        s1_valid_r;
  aup_item_t   s1_item_r;

  // result register
  logic        out_valid_r;
  aup_result_t out_result_r;

  aup_result_t result;
  logic        out_free;
  logic        s1_step;

  // The result register takes a new transaction when empty or being drained.
  assign out_free = !out_valid_r || out_ch.ready;
  // Characters never need the result register; a marker waits for it.
  assign s1_step  = s1_valid_r && (s1_item_r.kind == KIND_CHAR || out_free);

  assign in_ch.ready = !s1_valid_r || s1_step;

  assign out_ch.valid = out_valid_r;
  assign out_ch.value = out_result_r.value;
  assign out_ch.ok    = out_result_r.ok;

  aup_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (s1_step),
    .item         (s1_item_r),
    .decimal_only (decimal_only_r),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decimal_only_r <= 1'b0;
    end else if (cfg_we) begin
      decimal_only_r <= cfg_wdata;
    end
  end

  // Load the input register on every accepted transaction; drop it once stepped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      s1_valid_r <= 1'b1;
    end else if (s1_step) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_item_r.kind      <= in_ch.kind;
      s1_item_r.character <= in_ch.character;
    end
  end

  // Capture the result when a marker steps; otherwise hold until taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_step && s1_item_r.kind == KIND_END) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_step && s1_item_r.kind == KIND_END) begin
      out_result_r <= result;
    end
  end

endmodule

FILE: rtl/aup_checker.sv
// ----------------------------------------------------------------------------
// aup_checker
// Port-level checks of the parser, bound to the top level.
// ----------------------------------------------------------------------------
`include "ascii_uint32_parser_defines.svh"

module aup_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_value,
  input logic        out_ok
);

  // A stalled result transaction holds its payload.
  `AUP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_value) && $stable(out_ok))

  // A failed parse reports zero.
  `AUP_ASSERT_NOW(a_fail_zero, out_valid && !out_ok, out_value == 32'd0)

  // With no result pending, nothing can block the input.
  `AUP_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready)

  // An idle input with no accept just before and no result leaves the output empty.
  `AUP_ASSERT_NEXT(a_idle_quiet, !out_valid && !in_valid && !$past(in_valid && in_ready), !out_valid)

endmodule

bind ascii_uint32_parser aup_checker u_aup_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_value (out_ch.value),
  .out_ok    (out_ch.ok)
);
